### design/torus_point_project_shade_defines.svh
// assertion macros used by the checker file
`ifndef TORUS_POINT_PROJECT_SHADE_DEFINES_SVH
`define TORUS_POINT_PROJECT_SHADE_DEFINES_SVH

// concurrent check that is switched off while reset is high
`define TPPS_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent check that also holds through reset
`define TPPS_ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/tpps_pkg.sv
// shared constants, types and tables of the torus point projector
package tpps_pkg;

   // field widths
   localparam int ANGLE_W    = 16;
   localparam int RADIUS_W   = 12;
   localparam int TRIG_W     = 18;
   localparam int CHAR_W     = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Z = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINOR = 4'd3;

   // register reset values
   localparam logic [RADIUS_W-1:0] MAJOR_RESET = 12'd512;
   localparam logic [RADIUS_W-1:0] MINOR_RESET = 12'd256;

   // default screen and shading geometry
   localparam int DEF_SCREEN_COLS  = 80;
   localparam int DEF_SCREEN_ROWS  = 22;
   localparam int DEF_SHADE_LEVELS = 12;

   // sine polynomial, Q16 coefficients
   localparam int POLY_W = 20;
   localparam logic signed [POLY_W-1:0] POLY_C1 = 20'sd102944;
   localparam logic signed [POLY_W-1:0] POLY_C3 = 20'sd42334;
   localparam logic signed [POLY_W-1:0] POLY_C5 = 20'sd5223;
   localparam logic signed [POLY_W-1:0] POLY_C7 = 20'sd307;
   localparam logic signed [POLY_W-1:0] POLY_C9 = 20'sd11;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

   // projection and lighting constants
   localparam logic signed [TRIG_W-1:0] INV_SQRT2 = 18'sd46341;
   localparam logic signed [24:0] DEPTH_OFFSET_Q = 25'sd327680;
   localparam logic signed [29:0] SCALE_X = 30'sd30;
   localparam logic signed [29:0] SCALE_Y = 30'sd15;
   localparam logic signed [14:0] SHIFT_X = 15'sd40;
   localparam logic signed [14:0] SHIFT_Y = 15'sd12;
   localparam int GRAD_LAST = 11;

   // pipeline geometry
   localparam int SIN_LAT     = 7;
   localparam int DIV_NUM_W   = 30;
   localparam int DIV_DEN_W   = 24;
   localparam int DIV_QB      = 12;
   localparam int DIV_Q_W     = DIV_QB + 2;
   localparam int DIV_LAT     = DIV_QB + 2;
   localparam int PRE_DIV_LAT = SIN_LAT + 9;
   localparam int LATENCY     = PRE_DIV_LAT + DIV_LAT + 1;

   // divider result
   typedef struct packed {
      logic                       ovf;
      logic signed [DIV_Q_W-1:0]  quot;
   } tpps_div_out_type;

   // brightness gradient
   function automatic logic [CHAR_W-1:0] gradient_char(input logic [3:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         4'd0:    c = 7'd46;   // .
         4'd1:    c = 7'd44;   // ,
         4'd2:    c = 7'd45;   // -
         4'd3:    c = 7'd126;  // ~
         4'd4:    c = 7'd58;   // :
         4'd5:    c = 7'd59;   // ;
         4'd6:    c = 7'd61;   // =
         4'd7:    c = 7'd33;   // !
         4'd8:    c = 7'd42;   // *
         4'd9:    c = 7'd35;   // #
         4'd10:   c = 7'd36;   // $
         default: c = 7'd64;   // @
      endcase
      return c;
   endfunction

endpackage

### design/tpps_sine.sv
// pipelined Q16 sine of a turn fraction, odd degree-9 polynomial
module tpps_sine (
   input  logic                                clock,
   input  logic [tpps_pkg::ANGLE_W-1:0]        angle,
   output logic signed [tpps_pkg::TRIG_W-1:0]  sine
);
   import tpps_pkg::*;

   localparam int X_W    = ANGLE_W + 1;
   localparam int PR_W   = POLY_W + X_W + 1;
   localparam int HORNER = 4;
   localparam logic [X_W-1:0] ONE_Q = 17'h10000;

   logic [X_W-1:0]               frac;
   logic [X_W-1:0]               x_in;
   logic [X_W-1:0]               x_ff [SIN_LAT-1];
   logic                         neg_ff [SIN_LAT-1];
   logic [2*X_W-1:0]             sq;
   logic [X_W-1:0]               x2_in;
   logic [X_W-1:0]               x2_ff [HORNER];
   logic signed [POLY_W-1:0]     p_in [HORNER];
   logic signed [POLY_W-1:0]     p_ff [HORNER];
   logic signed [PR_W-1:0]       last_prod;
   logic signed [21:0]           last_sh;
   logic [X_W-1:0]               clamped;
   logic signed [TRIG_W-1:0]     sine_in;
   logic signed [TRIG_W-1:0]     sine_ff;

   function automatic logic signed [POLY_W-1:0] coef(input int k);
      logic signed [POLY_W-1:0] c;
      case (k)
         0:       c = POLY_C7;
         1:       c = POLY_C5;
         2:       c = POLY_C3;
         default: c = POLY_C1;
      endcase
      return c;
   endfunction

   // fold the angle into a quarter turn
   always_comb begin
      frac = {1'b0, angle[13:0], 2'b00};
      x_in = angle[14] ? (ONE_Q - frac) : frac;
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= x_in;
      neg_ff[0] <= angle[15];
      for (int i = 1; i < SIN_LAT - 1; i++) begin
         x_ff[i]   <= x_ff[i-1];
         neg_ff[i] <= neg_ff[i-1];
      end
   end

   // square of the folded angle
   always_comb begin
      sq    = x_ff[0] * x_ff[0];
      x2_in = sq[X_W+15:16];
   end

   always_ff @(posedge clock) begin
      x2_ff[0] <= x2_in;
      for (int i = 1; i < HORNER; i++) begin
         x2_ff[i] <= x2_ff[i-1];
      end
   end

   // one horner step per stage
   for (genvar k = 0; k < HORNER; k++) begin : g_horner
      logic signed [POLY_W-1:0] p_src;
      logic signed [PR_W-1:0]   prod;
      always_comb begin
         p_src   = (k == 0) ? POLY_C9 : p_ff[(k == 0) ? 0 : k-1];
         prod    = PR_W'(p_src) * PR_W'($signed({1'b0, x2_ff[k]}));
         p_in[k] = coef(k) - POLY_W'(prod >>> 16);
      end
      always_ff @(posedge clock) begin
         p_ff[k] <= p_in[k];
      end
   end

   // final multiply, clamp and sign
   always_comb begin
      last_prod = PR_W'(p_ff[HORNER-1]) * PR_W'($signed({1'b0, x_ff[SIN_LAT-2]}));
      last_sh   = $signed(last_prod[37:16]);
      if (last_sh > 22'sd65536) begin
         clamped = ONE_Q;
      end else if (last_sh < 22'sd0) begin
         clamped = '0;
      end else begin
         clamped = last_sh[X_W-1:0];
      end
      sine_in = neg_ff[SIN_LAT-2] ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

### design/tpps_divider.sv
// pipelined floor division with a bounded quotient, one bit per stage
module tpps_divider (
   input  logic                                  clock,
   input  logic signed [tpps_pkg::DIV_NUM_W-1:0] num,
   input  logic [tpps_pkg::DIV_DEN_W-1:0]        den,
   output tpps_pkg::tpps_div_out_type            result
);
   import tpps_pkg::*;

   localparam int CMP_W = DIV_DEN_W + DIV_QB;

   logic [DIV_NUM_W-1:0]  mag_in;
   logic                  ovf_in;
   logic [DIV_NUM_W-1:0]  rem_ff [DIV_QB+1];
   logic [DIV_QB-1:0]     quo_ff [DIV_QB+1];
   logic [DIV_DEN_W-1:0]  den_ff [DIV_QB+1];
   logic                  neg_ff [DIV_QB+1];
   logic                  ovf_ff [DIV_QB+1];
   logic [DIV_QB:0]       ceil_q;
   tpps_div_out_type      result_in;
   tpps_div_out_type      result_ff;

   // magnitude and range check
   always_comb begin
      mag_in = num[DIV_NUM_W-1] ? $unsigned(-num) : $unsigned(num);
      ovf_in = CMP_W'(mag_in) >= {den, {DIV_QB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_in;
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      neg_ff[0] <= num[DIV_NUM_W-1];
      ovf_ff[0] <= ovf_in;
   end

   // restoring steps, most significant quotient bit first
   for (genvar s = 1; s <= DIV_QB; s++) begin : g_step
      localparam int B = DIV_QB - s;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] rem_wide;
      logic             ge;
      always_comb begin
         trial    = CMP_W'(den_ff[s-1]) << B;
         rem_wide = CMP_W'(rem_ff[s-1]);
         ge       = rem_wide >= trial;
      end
      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? DIV_NUM_W'(rem_wide - trial) : rem_ff[s-1];
         quo_ff[s] <= quo_ff[s-1] | (DIV_QB'(ge) << B);
         den_ff[s] <= den_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   // round toward minus infinity for negative numerators
   always_comb begin
      ceil_q = {1'b0, quo_ff[DIV_QB]} + (DIV_QB+1)'(rem_ff[DIV_QB] != '0);
      result_in.ovf  = ovf_ff[DIV_QB];
      result_in.quot = neg_ff[DIV_QB] ? -$signed({1'b0, ceil_q})
                                      : $signed({2'b00, quo_ff[DIV_QB]});
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### design/torus_point_project_shade.sv
// top level: torus surface point to screen cell and shade character
//
//  channel   ports                                 handshake
//  request   req_tube_angle, req_ring_angle        start high and busy low
//  result    rsp_screen_col .. rsp_shade_char      rsp_valid for one cycle
//  config    csr_index, csr_wdata                  csr_wen high
//
// one item enters every cycle; busy never rises
// each result passes in order through the sine units, the radius, rotation and
// shading multiplies, the divider and one output register
// the result side has no stall, results leave in the order items came in
// reset clears the pipeline valid bits and loads the register defaults
module torus_point_project_shade #(
   parameter int SCREEN_COLS  = tpps_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS  = tpps_pkg::DEF_SCREEN_ROWS,
   parameter int SHADE_LEVELS = tpps_pkg::DEF_SHADE_LEVELS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [tpps_pkg::ANGLE_W-1:0]            req_tube_angle,
   input  logic [tpps_pkg::ANGLE_W-1:0]            req_ring_angle,
   input  logic                                    csr_wen,
   input  logic [tpps_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tpps_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic                                    rsp_valid,
   output logic [$clog2(SCREEN_COLS)-1:0]          rsp_screen_col,
   output logic [$clog2(SCREEN_ROWS)-1:0]          rsp_screen_row,
   output logic                                    rsp_visible,
   output logic [$clog2(SHADE_LEVELS)-1:0]         rsp_shade_level,
   output logic [tpps_pkg::CHAR_W-1:0]             rsp_shade_char
);
   import tpps_pkg::*;

   localparam int COL_W     = $clog2(SCREEN_COLS);
   localparam int ROW_W     = $clog2(SCREEN_ROWS);
   localparam int LVL_W     = $clog2(SHADE_LEVELS);
   localparam int CHAR_STG  = SIN_LAT + 6;
   localparam int SHD_N     = PRE_DIV_LAT + DIV_LAT - CHAR_STG + 1;
   localparam logic [6:0] LEVELS_M1 = 7'(SHADE_LEVELS - 1);

   typedef struct packed {
      logic [LVL_W-1:0]  level;
      logic [CHAR_W-1:0] char_code;
   } shade_type;

   // configuration registers
   logic [ANGLE_W-1:0]   rot_x_ff, rot_x_in;
   logic [ANGLE_W-1:0]   rot_z_ff, rot_z_in;
   logic [RADIUS_W-1:0]  major_ff, major_in;
   logic [RADIUS_W-1:0]  minor_ff, minor_in;

   always_comb begin
      rot_x_in = rot_x_ff;
      rot_z_in = rot_z_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ROT_X: rot_x_in = csr_wdata[ANGLE_W-1:0];
            CSR_ROT_Z: rot_z_in = csr_wdata[ANGLE_W-1:0];
            CSR_MAJOR: major_in = csr_wdata[RADIUS_W-1:0];
            CSR_MINOR: minor_in = csr_wdata[RADIUS_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff <= '0;
         rot_z_ff <= '0;
         major_ff <= MAJOR_RESET;
         minor_ff <= MINOR_RESET;
      end else begin
         rot_x_ff <= rot_x_in;
         rot_z_ff <= rot_z_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
      end
   end

   // valid bits travel with the item
   logic [LATENCY-1:0] v_ff, v_in;

   assign busy = 1'b0;
   assign v_in = {v_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // sines and cosines of the item angles and the rotation angles
   logic signed [TRIG_W-1:0] ct, st, cp, sp, ca, sa, cb, sb;

   tpps_sine u_cos_t (.clock(clock), .angle(req_tube_angle + QUARTER_TURN), .sine(ct));
   tpps_sine u_sin_t (.clock(clock), .angle(req_tube_angle),                .sine(st));
   tpps_sine u_cos_p (.clock(clock), .angle(req_ring_angle + QUARTER_TURN), .sine(cp));
   tpps_sine u_sin_p (.clock(clock), .angle(req_ring_angle),                .sine(sp));
   tpps_sine u_cos_a (.clock(clock), .angle(rot_x_ff + QUARTER_TURN),       .sine(ca));
   tpps_sine u_sin_a (.clock(clock), .angle(rot_x_ff),                      .sine(sa));
   tpps_sine u_cos_b (.clock(clock), .angle(rot_z_ff + QUARTER_TURN),       .sine(cb));
   tpps_sine u_sin_b (.clock(clock), .angle(rot_z_ff),                      .sine(sb));

   // radius products and normal term
   logic signed [30:0]       rct_ff, rct_in, rst_ff, rst_in;
   logic signed [35:0]       ctsp_ff, ctsp_in;
   logic signed [TRIG_W-1:0] st8_ff, cp8_ff, sp8_ff, cp9_ff, sp9_ff;

   always_comb begin
      rct_in  = 31'($signed({1'b0, minor_ff})) * 31'(ct);
      rst_in  = 31'($signed({1'b0, minor_ff})) * 31'(st);
      ctsp_in = 36'(ct) * 36'(sp);
   end

   always_ff @(posedge clock) begin
      rct_ff  <= rct_in;
      rst_ff  <= rst_in;
      ctsp_ff <= ctsp_in;
      st8_ff  <= st;
      cp8_ff  <= cp;
      sp8_ff  <= sp;
   end

   // ring distance, height and unscaled brightness
   logic signed [22:0] w_ff, w_in, z9_ff, z9_in;
   logic signed [20:0] nt_ff, nt_in;

   always_comb begin
      w_in  = $signed({3'b000, major_ff, 8'h00}) + $signed(rct_ff[30:8]);
      z9_in = $signed(rst_ff[30:8]);
      nt_in = 21'($signed(ctsp_ff[35:16])) - 21'(st8_ff);
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      z9_ff  <= z9_in;
      nt_ff  <= nt_in;
      cp9_ff <= cp8_ff;
      sp9_ff <= sp8_ff;
   end

   // ring position products and light product
   logic signed [40:0] wcp_ff, wcp_in, wsp_ff, wsp_in;
   logic signed [38:0] bprod_ff, bprod_in;
   logic signed [22:0] z10_ff;

   always_comb begin
      wcp_in   = 41'(w_ff) * 41'(cp9_ff);
      wsp_in   = 41'(w_ff) * 41'(sp9_ff);
      bprod_in = 39'(nt_ff) * 39'(INV_SQRT2);
   end

   always_ff @(posedge clock) begin
      wcp_ff   <= wcp_in;
      wsp_ff   <= wsp_in;
      bprod_ff <= bprod_in;
      z10_ff   <= z9_ff;
   end

   // point coordinates and clamped brightness
   logic signed [22:0] x11_ff, x11_in, y11_ff, y11_in, z11_ff;
   logic signed [22:0] bsh;
   logic [16:0]        bcl_ff, bcl_in;

   always_comb begin
      x11_in = $signed(wcp_ff[38:16]);
      y11_in = $signed(wsp_ff[38:16]);
      bsh    = $signed(bprod_ff[38:16]);
      if (bsh > 23'sd65536) begin
         bcl_in = 17'h10000;
      end else if (bsh < 23'sd0) begin
         bcl_in = '0;
      end else begin
         bcl_in = bsh[16:0];
      end
   end

   always_ff @(posedge clock) begin
      x11_ff <= x11_in;
      y11_ff <= y11_in;
      z11_ff <= z10_ff;
      bcl_ff <= bcl_in;
   end

   // rotation about x, products; shade level
   logic signed [41:0] yca_ff, yca_in, zsa_ff, zsa_in, ysa_ff, ysa_in, zca_ff, zca_in;
   logic signed [22:0] x12_ff;
   logic [23:0]        lprod;
   logic [LVL_W-1:0]   level_ff, level_in;

   always_comb begin
      yca_in   = 42'(y11_ff) * 42'(ca);
      zsa_in   = 42'(z11_ff) * 42'(sa);
      ysa_in   = 42'(y11_ff) * 42'(sa);
      zca_in   = 42'(z11_ff) * 42'(ca);
      lprod    = 24'(bcl_ff) * 24'(LEVELS_M1);
      level_in = lprod[16 +: LVL_W];
   end

   always_ff @(posedge clock) begin
      yca_ff   <= yca_in;
      zsa_ff   <= zsa_in;
      ysa_ff   <= ysa_in;
      zca_ff   <= zca_in;
      x12_ff   <= x11_ff;
      level_ff <= level_in;
   end

   // rotation about x, sums; gradient lookup
   logic signed [41:0] ydiff, zsum;
   logic signed [23:0] y1_ff, y1_in, z1_ff, z1_in;
   logic signed [22:0] x13_ff;
   logic [11:0]        lvl11;
   logic [3:0]         grad_idx;
   shade_type          shd_in;
   shade_type          shd_ff [SHD_N];

   always_comb begin
      ydiff = yca_ff - zsa_ff;
      zsum  = ysa_ff + zca_ff;
      y1_in = $signed(ydiff[39:16]);
      z1_in = $signed(zsum[39:16]);
      lvl11 = 12'(level_ff) * 12'd11;
      grad_idx = '0;
      for (int k = 1; k <= GRAD_LAST; k++) begin
         if (12'(k * (SHADE_LEVELS - 1)) <= lvl11) begin
            grad_idx = 4'(k);
         end
      end
      shd_in.level     = level_ff;
      shd_in.char_code = gradient_char(grad_idx);
   end

   always_ff @(posedge clock) begin
      y1_ff     <= y1_in;
      z1_ff     <= z1_in;
      x13_ff    <= x12_ff;
      shd_ff[0] <= shd_in;
      for (int i = 1; i < SHD_N; i++) begin
         shd_ff[i] <= shd_ff[i-1];
      end
   end

   // rotation about z, products
   logic signed [41:0] xcb_ff, xcb_in, y1sb_ff, y1sb_in, xsb_ff, xsb_in, y1cb_ff, y1cb_in;
   logic signed [23:0] z14_ff;

   always_comb begin
      xcb_in  = 42'(x13_ff) * 42'(cb);
      y1sb_in = 42'(y1_ff) * 42'(sb);
      xsb_in  = 42'(x13_ff) * 42'(sb);
      y1cb_in = 42'(y1_ff) * 42'(cb);
   end

   always_ff @(posedge clock) begin
      xcb_ff  <= xcb_in;
      y1sb_ff <= y1sb_in;
      xsb_ff  <= xsb_in;
      y1cb_ff <= y1cb_in;
      z14_ff  <= z1_ff;
   end

   // rotation about z, sums; depth
   logic signed [41:0] xdiff, ysum;
   logic signed [23:0] x2_ff, x2_in, y2_ff, y2_in;
   logic signed [24:0] d_ff, d_in;

   always_comb begin
      xdiff = xcb_ff - y1sb_ff;
      ysum  = xsb_ff + y1cb_ff;
      x2_in = $signed(xdiff[39:16]);
      y2_in = $signed(ysum[39:16]);
      d_in  = 25'(z14_ff) + DEPTH_OFFSET_Q;
   end

   always_ff @(posedge clock) begin
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      d_ff  <= d_in;
   end

   // screen scaling of the numerators
   logic signed [DIV_NUM_W-1:0] ncol_ff, ncol_in, nrow_ff, nrow_in;
   logic [DIV_DEN_W-1:0]        den_ff, den_in;
   logic                        dpos_ff [DIV_LAT+1];

   always_comb begin
      ncol_in = DIV_NUM_W'(x2_ff) * SCALE_X;
      nrow_in = DIV_NUM_W'(y2_ff) * SCALE_Y;
      den_in  = d_ff[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      ncol_ff    <= ncol_in;
      nrow_ff    <= nrow_in;
      den_ff     <= den_in;
      dpos_ff[0] <= d_ff > 25'sd0;
      for (int i = 1; i <= DIV_LAT; i++) begin
         dpos_ff[i] <= dpos_ff[i-1];
      end
   end

   // perspective divides
   tpps_div_out_type col_div, row_div;

   tpps_divider u_div_col (.clock(clock), .num(ncol_ff), .den(den_ff), .result(col_div));
   tpps_divider u_div_row (.clock(clock), .num(nrow_ff), .den(den_ff), .result(row_div));

   // screen cell and visibility
   logic signed [14:0]   ccol, crow;
   logic                 vis_in, vis_ff;
   logic [COL_W-1:0]     col_in, col_ff;
   logic [ROW_W-1:0]     row_in, row_ff;
   logic [LVL_W-1:0]     lvl_out_ff;
   logic [CHAR_W-1:0]    char_out_ff;

   always_comb begin
      ccol   = 15'(col_div.quot) + SHIFT_X;
      crow   = 15'(row_div.quot) + SHIFT_Y;
      vis_in = dpos_ff[DIV_LAT] && !col_div.ovf && !row_div.ovf
               && ccol >= 15'sd0 && ccol < $signed(15'(SCREEN_COLS))
               && crow >= 15'sd0 && crow < $signed(15'(SCREEN_ROWS));
      col_in = vis_in ? ccol[COL_W-1:0] : '0;
      row_in = vis_in ? crow[ROW_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      vis_ff      <= vis_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      lvl_out_ff  <= shd_ff[SHD_N-1].level;
      char_out_ff <= shd_ff[SHD_N-1].char_code;
   end

   assign rsp_valid       = v_ff[LATENCY-1];
   assign rsp_screen_col  = col_ff;
   assign rsp_screen_row  = row_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_shade_level = lvl_out_ff;
   assign rsp_shade_char  = char_out_ff;

endmodule

### design/tpps_checker.sv
// port level checks of the torus point projector and their binding
`include "torus_point_project_shade_defines.svh"

module tpps_checker #(
   parameter int SCREEN_COLS  = tpps_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS  = tpps_pkg::DEF_SCREEN_ROWS,
   parameter int SHADE_LEVELS = tpps_pkg::DEF_SHADE_LEVELS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [$clog2(SCREEN_COLS)-1:0]   rsp_screen_col,
   input logic [$clog2(SCREEN_ROWS)-1:0]   rsp_screen_row,
   input logic                             rsp_visible,
   input logic [$clog2(SHADE_LEVELS)-1:0]  rsp_shade_level
);
   import tpps_pkg::*;

   // every accepted item comes out at the end of the valid pipeline
   `TPPS_ASSERT_RUN(a_latency, (start && !busy) |-> ##LATENCY rsp_valid, "item result missing")

   // nothing comes out right after reset
   `TPPS_ASSERT_ALL(a_reset_quiet, reset |=> !rsp_valid, "result right after reset")

   // a visible point lies on the screen
   `TPPS_ASSERT_RUN(a_on_screen,
      (rsp_valid && rsp_visible) |-> (rsp_screen_col < SCREEN_COLS && rsp_screen_row < SCREEN_ROWS),
      "visible point off screen")

   // a hidden point reports cell zero
   `TPPS_ASSERT_RUN(a_hidden_zero,
      (rsp_valid && !rsp_visible) |-> (rsp_screen_col == 0 && rsp_screen_row == 0),
      "hidden point with nonzero cell")

   // shade level within the configured count
   `TPPS_ASSERT_RUN(a_level_range, rsp_valid |-> (rsp_shade_level < SHADE_LEVELS),
      "shade level out of range")

endmodule

bind torus_point_project_shade tpps_checker #(
   .SCREEN_COLS  (SCREEN_COLS),
   .SCREEN_ROWS  (SCREEN_ROWS),
   .SHADE_LEVELS (SHADE_LEVELS)
) u_tpps_checker (.*);

### test/tb_torus_point_project_shade.sv
// testbench for the torus point projector: directed and random items checked against a predictor
module tb_torus_point_project_shade;
   timeunit 1ns;
   timeprecision 1ps;
   import tpps_pkg::*;

   localparam int COLS_W  = $clog2(DEF_SCREEN_COLS);
   localparam int ROWS_W  = $clog2(DEF_SCREEN_ROWS);
   localparam int LEVEL_W = $clog2(DEF_SHADE_LEVELS);

   // register index that maps to no register
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 4'd9;

   // one projected, shaded point
   typedef struct packed {
      logic [COLS_W-1:0]  col;
      logic [ROWS_W-1:0]  row;
      logic               vis;
      logic [LEVEL_W-1:0] level;
      logic [CHAR_W-1:0]  chr;
   } cell_type;

   // projector settings as the testbench sees them
   logic [ANGLE_W-1:0]  set_rot_x = '0;
   logic [ANGLE_W-1:0]  set_rot_z = '0;
   logic [RADIUS_W-1:0] set_major = MAJOR_RESET;
   logic [RADIUS_W-1:0] set_minor = MINOR_RESET;

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // odd polynomial sine over a quarter turn
   function automatic longint quarter_sin(longint x);
      longint x2, p;
      x2 = (x * x) >>> 16;
      p = 11;
      p = 307 - ((p * x2) >>> 16);
      p = 5223 - ((p * x2) >>> 16);
      p = 42334 - ((p * x2) >>> 16);
      p = 102944 - ((p * x2) >>> 16);
      p = (p * x) >>> 16;
      if (p > 65536) p = 65536;
      if (p < 0) p = 0;
      return p;
   endfunction

   function automatic longint sin_q(logic [15:0] a);
      longint x, s;
      x = longint'(a[13:0]) << 2;
      s = a[14] ? quarter_sin(65536 - x) : quarter_sin(x);
      return a[15] ? -s : s;
   endfunction

   function automatic longint cos_q(logic [15:0] a);
      return sin_q(a + 16'h4000);
   endfunction

   function automatic cell_type project_point(logic [15:0] t, logic [15:0] p);
      longint ct, st, cp, sp, ca, sa, cb, sb, rr, w, x, y, z, y1, z1, x2, y2, d, c, r, nt, b;
      longint level;
      cell_type o;
      ct = cos_q(t); st = sin_q(t); cp = cos_q(p); sp = sin_q(p);
      ca = cos_q(set_rot_x); sa = sin_q(set_rot_x);
      cb = cos_q(set_rot_z); sb = sin_q(set_rot_z);
      rr = longint'(set_minor);
      o = '0;
      w = (longint'(set_major) << 8) + floor_sh(rr * ct, 8);
      x = floor_sh(w * cp, 16);
      y = floor_sh(w * sp, 16);
      z = floor_sh(rr * st, 8);
      y1 = floor_sh(y * ca - z * sa, 16);
      z1 = floor_sh(y * sa + z * ca, 16);
      x2 = floor_sh(x * cb - y1 * sb, 16);
      y2 = floor_sh(x * sb + y1 * cb, 16);
      d = z1 + (longint'(5) << 16);
      // depth must be positive and the cell on screen
      if (d > 0) begin
         c = floor_quot(30 * x2, d) + 40;
         r = floor_quot(15 * y2, d) + 12;
         if (c >= 0 && c < DEF_SCREEN_COLS && r >= 0 && r < DEF_SCREEN_ROWS) begin
            o.vis = 1'b1;
            o.col = c[COLS_W-1:0];
            o.row = r[ROWS_W-1:0];
         end
      end
      // lambert shade against the fixed light
      nt = floor_sh(ct * sp, 16) - st;
      b = floor_sh(nt * 46341, 16);
      if (b > 65536) b = 65536;
      if (b < 0) b = 0;
      level = (b * (DEF_SHADE_LEVELS - 1)) >>> 16;
      o.level = level[LEVEL_W-1:0];
      o.chr = gradient_char(4'((level * 11) / (DEF_SHADE_LEVELS - 1)));
      return o;
   endfunction

   // queue of expected cells and mismatch bookkeeping
   class cell_board;
      cell_type pending[$];
      int errors = 0;
      int checked = 0;
      int visible_cnt = 0;

      function void note_item(cell_type e);
         pending.push_back(e);
      endfunction

      function void check_cell(cell_type a);
         cell_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result col=%0d row=%0d", a.col, a.row);
            return;
         end
         e = pending.pop_front();
         if (a.vis) visible_cnt++;
         if (a !== e) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp col=%0d row=%0d vis=%0d lvl=%0d chr=%0d,",
                         " got col=%0d row=%0d vis=%0d lvl=%0d chr=%0d"},
                        e.col, e.row, e.vis, e.level, e.chr,
                        a.col, a.row, a.vis, a.level, a.chr);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic [ANGLE_W-1:0] req_tube_angle = '0, req_ring_angle = '0;
   logic csr_wen = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic busy, rsp_valid, rsp_visible;
   logic [COLS_W-1:0] rsp_screen_col;
   logic [ROWS_W-1:0] rsp_screen_row;
   logic [LEVEL_W-1:0] rsp_shade_level;
   logic [CHAR_W-1:0] rsp_shade_char;

   cell_board board = new();
   int item_cnt = 0;
   bit calm = 0;

   torus_point_project_shade dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_cell({rsp_screen_col, rsp_screen_row, rsp_visible, rsp_shade_level,
                           rsp_shade_char});
   end

   // one register write, then the write port goes quiet before the task returns
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         CSR_ROT_X: set_rot_x = val;
         CSR_ROT_Z: set_rot_z = val;
         CSR_MAJOR: set_major = val[RADIUS_W-1:0];
         CSR_MINOR: set_minor = val[RADIUS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // send one item, occasionally after a pause with start low, never while calm is set
   task automatic send_point(logic [15:0] t, logic [15:0] p);
      if (!calm && $urandom_range(99) < 14) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1; req_tube_angle <= t; req_ring_angle <= p;
      do @(posedge clock); while (busy);
      board.note_item(project_point(t, p));
      item_cnt++;
   endtask

   task automatic drain;
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      logic [15:0] edge_ang[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                   16'h3FFF, 16'h2000, 16'hA000};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset settings, extreme angles
      for (int i = 0; i < 8; i++) send_point(edge_ang[i], edge_ang[(i * 3) % 8]);
      drain();
      // directed: radii at extremes force depth and off-screen cases
      write_reg(CSR_MAJOR, 16'hFFFF); write_reg(CSR_MINOR, 16'h0FFF);
      write_reg(CSR_ROT_X, 16'h4000); write_reg(CSR_ROT_Z, 16'hFFFF);
      write_reg(CSR_NONE, 16'h1234);
      for (int i = 0; i < 8; i++) send_point(edge_ang[i], edge_ang[7 - i]);
      drain();
      write_reg(CSR_MAJOR, 16'd0); write_reg(CSR_MINOR, 16'd0);
      for (int i = 0; i < 4; i++) send_point(edge_ang[i], edge_ang[i + 4]);
      drain();
      // random phases with varied settings
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_ROT_X, 16'($urandom));
         write_reg(CSR_ROT_Z, 16'($urandom));
         write_reg(CSR_MAJOR, (ph == 9) ? 16'h0FFF : 16'($urandom_range(128, 1024)));
         write_reg(CSR_MINOR, (ph == 8) ? 16'h0000 : 16'($urandom_range(0, 512)));
         calm = (ph == 4);
         for (int i = 0; i < 150; i++) send_point(16'($urandom), 16'($urandom));
         calm = 0;
         drain();
      end
      $display("items sent: %0d, results checked: %0d, visible: %0d over 13 settings",
               item_cnt, board.checked, board.visible_cnt);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // run limit
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
